FILE: hw/rtl/memory_object_table_unit_macros.svh
// ---------------------------------------------------------------------------
// Memory object table unit: assertion macros
// Shared concurrent assertion forms. They compile away under NO_ASSERTIONS.
// ---------------------------------------------------------------------------
`ifndef MEMORY_OBJECT_TABLE_UNIT_MACROS_SVH
`define MEMORY_OBJECT_TABLE_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define MOT_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define MOT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define MOT_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define MOT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: hw/rtl/mot_pkg.sv
// ---------------------------------------------------------------------------
// Memory object table package
// Field widths, command and status codes, controller/datapath structs.
// ---------------------------------------------------------------------------
package mot_pkg;

    localparam int ID_W    = 64;
    localparam int FLAG_W  = 16;
    localparam int RSVD_W  = 32;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 3;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FLAG_PRIVATE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLAG_SHAREABLE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLAG_GUEST     = 2'd2;

    localparam logic [FLAG_W-1:0] FLAG_PRIVATE_RST   = 16'd1;
    localparam logic [FLAG_W-1:0] FLAG_SHAREABLE_RST = 16'd2;
    localparam logic [FLAG_W-1:0] FLAG_GUEST_RST     = 16'd4;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC    = 2'd0,
        CMD_RELEASE  = 2'd1,
        CMD_SET_BUSY = 2'd2
    } command_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 3'd0,
        ST_INVALID   = 3'd1,
        ST_EXHAUSTED = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_DENIED    = 3'd4,
        ST_BUSY      = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_DECIDE,
        S_FINISH
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic    idle;
        logic    scan_start;
        logic    scan;
        logic    load_rsp;
        logic    commit;
        status_t status;
    } ctl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic              take;
        logic [CMD_W-1:0]  command;
        logic              req_bad;
        logic              ident_full;
        logic              hit;
        logic              miss;
        logic              owner_ok;
        logic              busy;
        logic              out_free;
    } dp_stat_t;

endpackage

FILE: hw/rtl/mot_req_if.sv
// ---------------------------------------------------------------------------
// Memory object table request channel
// Valid/ready channel carrying one command request.
// ---------------------------------------------------------------------------
interface mot_req_if;
    logic                          valid;
    logic                          ready;
    logic [mot_pkg::CMD_W-1:0]     command;
    logic [mot_pkg::ID_W-1:0]      owner_id;
    logic [mot_pkg::ID_W-1:0]      object_id;
    logic [mot_pkg::ID_W-1:0]      region_bytes;
    logic [mot_pkg::FLAG_W-1:0]    flag_code;
    logic [mot_pkg::RSVD_W-1:0]    reserved_word;
    logic                          busy_mark;

    modport source (
        output valid, command, owner_id, object_id, region_bytes, flag_code,
               reserved_word, busy_mark,
        input  ready
    );

    modport sink (
        input  valid, command, owner_id, object_id, region_bytes, flag_code,
               reserved_word, busy_mark,
        output ready
    );
endinterface

FILE: hw/rtl/mot_rsp_if.sv
// ---------------------------------------------------------------------------
// Memory object table response channel
// Valid/ready channel carrying one status and identifier.
// ---------------------------------------------------------------------------
interface mot_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [mot_pkg::STAT_W-1:0]  status;
    logic [mot_pkg::ID_W-1:0]    new_object_id;

    modport source (
        output valid, status, new_object_id,
        input  ready
    );

    modport sink (
        input  valid, status, new_object_id,
        output ready
    );
endinterface

FILE: hw/rtl/mot_ctrl.sv
// ---------------------------------------------------------------------------
// Memory object table controller
// Sequences check, slot scan, decision and response/commit for one request.
// ---------------------------------------------------------------------------
module mot_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  mot_pkg::dp_stat_t stat,
    output mot_pkg::ctl_cmd_t cmd
);

    mot_pkg::state_t  state_reg;
    mot_pkg::state_t  state_next;
    mot_pkg::status_t st_reg;
    mot_pkg::status_t st_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mot_pkg::S_IDLE;
            st_reg    <= mot_pkg::ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            st_reg    <= st_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        st_next        = st_reg;
        cmd.idle       = 1'b0;
        cmd.scan_start = 1'b0;
        cmd.scan       = 1'b0;
        cmd.load_rsp   = 1'b0;
        cmd.commit     = 1'b0;
        cmd.status     = st_reg;
        case (state_reg)
            mot_pkg::S_IDLE:
            begin
                cmd.idle = 1'b1;
                if (stat.take)
                begin
                    state_next = mot_pkg::S_CHECK;
                end
            end
            mot_pkg::S_CHECK:
            begin
                if (stat.req_bad)
                begin
                    st_next    = mot_pkg::ST_INVALID;
                    state_next = mot_pkg::S_FINISH;
                end
                else if (stat.command == mot_pkg::CMD_ALLOC && stat.ident_full)
                begin
                    st_next    = mot_pkg::ST_EXHAUSTED;
                    state_next = mot_pkg::S_FINISH;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = mot_pkg::S_SCAN;
                end
            end
            mot_pkg::S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.hit)
                begin
                    state_next = mot_pkg::S_DECIDE;
                end
                else if (stat.miss)
                begin
                    st_next    = (stat.command == mot_pkg::CMD_ALLOC) ?
                                 mot_pkg::ST_EXHAUSTED : mot_pkg::ST_NOT_FOUND;
                    state_next = mot_pkg::S_FINISH;
                end
            end
            mot_pkg::S_DECIDE:
            begin
                if (stat.command == mot_pkg::CMD_RELEASE && !stat.owner_ok)
                begin
                    st_next = mot_pkg::ST_DENIED;
                end
                else if (stat.command == mot_pkg::CMD_RELEASE && stat.busy)
                begin
                    st_next = mot_pkg::ST_BUSY;
                end
                else
                begin
                    st_next = mot_pkg::ST_OK;
                end
                state_next = mot_pkg::S_FINISH;
            end
            mot_pkg::S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.load_rsp = 1'b1;
                    cmd.commit   = (st_reg == mot_pkg::ST_OK);
                    state_next   = mot_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = mot_pkg::S_IDLE;
            end
        endcase
    end

endmodule

FILE: hw/rtl/mot_datapath.sv
// ---------------------------------------------------------------------------
// Memory object table datapath
// Request and config registers, slot table, scan pipeline, response buffer.
// ---------------------------------------------------------------------------
module mot_datapath #(
    parameter int SLOTS      = 16,
    parameter int PAGE_SHIFT = 12
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    mot_req_if.sink                          req,
    mot_rsp_if.source                        rsp,
    input  logic                             cfg_we,
    input  logic [mot_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mot_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  mot_pkg::ctl_cmd_t                cmd,
    output mot_pkg::dp_stat_t                stat
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);
    localparam logic [mot_pkg::ID_W-1:0] PAGE_MASK =
        (64'd1 << PAGE_SHIFT) - 64'd1;

    // request
    logic [mot_pkg::CMD_W-1:0]   cmd_reg;
    logic [mot_pkg::ID_W-1:0]    owner_reg;
    logic [mot_pkg::ID_W-1:0]    obj_reg;
    logic [mot_pkg::ID_W-1:0]    bytes_reg;
    logic [mot_pkg::FLAG_W-1:0]  flag_reg;
    logic [mot_pkg::RSVD_W-1:0]  rsvd_reg;
    logic                        mark_reg;

    // config
    logic [mot_pkg::FLAG_W-1:0]  flag_priv_reg;
    logic [mot_pkg::FLAG_W-1:0]  flag_share_reg;
    logic [mot_pkg::FLAG_W-1:0]  flag_guest_reg;

    // table
    logic [mot_pkg::ID_W-1:0]    next_ident_reg;
    logic [SLOTS-1:0]            valid_reg;
    logic [SLOTS-1:0]            busy_reg;
    logic [mot_pkg::ID_W-1:0]    mem_ident [SLOTS];
    logic [mot_pkg::ID_W-1:0]    mem_owner [SLOTS];

    // scan
    logic [CW-1:0]               scan_cnt_reg;
    logic                        rd_pend_reg;
    logic [IW-1:0]               rd_idx_reg;
    logic [mot_pkg::ID_W-1:0]    rd_ident_reg;
    logic [mot_pkg::ID_W-1:0]    rd_owner_reg;
    logic [IW-1:0]               hit_idx_reg;
    logic                        own_ok_reg;
    logic                        hit_busy_reg;

    // response buffer
    logic                        out_vld_reg;
    logic [mot_pkg::STAT_W-1:0]  out_status_reg;
    logic [mot_pkg::ID_W-1:0]    out_id_reg;

    logic take;
    logic is_alloc;
    logic flag_ok;
    logic req_bad;
    logic issue;
    logic match;
    logic hit;
    logic give_id;

    assign take     = req.valid && cmd.idle;
    assign is_alloc = (cmd_reg == mot_pkg::CMD_ALLOC);
    assign flag_ok  = (flag_reg == flag_priv_reg) || (flag_reg == flag_share_reg) ||
                      (flag_reg == flag_guest_reg);

    always_comb
    begin
        case (cmd_reg)
            mot_pkg::CMD_ALLOC:
                req_bad = (owner_reg == '0) || (rsvd_reg != '0) || (bytes_reg == '0) ||
                          ((bytes_reg & PAGE_MASK) != '0) || !flag_ok;
            mot_pkg::CMD_RELEASE:
                req_bad = (obj_reg == '0) || (owner_reg == '0);
            mot_pkg::CMD_SET_BUSY:
                req_bad = (obj_reg == '0);
            default:
                req_bad = 1'b1;
        endcase
    end

    // allocate looks for a free slot, the others for a live identifier
    assign match = is_alloc ? !valid_reg[rd_idx_reg] :
                   (valid_reg[rd_idx_reg] && (rd_ident_reg == obj_reg));
    assign issue = cmd.scan && (scan_cnt_reg != SLOTS_C);
    assign hit   = cmd.scan && rd_pend_reg && match;
    assign give_id = (cmd.status == mot_pkg::ST_OK) && is_alloc;

    assign stat.take       = take;
    assign stat.command    = cmd_reg;
    assign stat.req_bad    = req_bad;
    assign stat.ident_full = (next_ident_reg == '1);
    assign stat.hit        = hit;
    assign stat.miss       = cmd.scan && !rd_pend_reg && (scan_cnt_reg == SLOTS_C);
    assign stat.owner_ok   = own_ok_reg;
    assign stat.busy       = hit_busy_reg;
    assign stat.out_free   = !out_vld_reg || rsp.ready;

    assign req.ready         = cmd.idle;
    assign rsp.valid         = out_vld_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.new_object_id = out_id_reg;

    // payload registers
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_reg   <= req.command;
            owner_reg <= req.owner_id;
            obj_reg   <= req.object_id;
            bytes_reg <= req.region_bytes;
            flag_reg  <= req.flag_code;
            rsvd_reg  <= req.reserved_word;
            mark_reg  <= req.busy_mark;
        end
        if (hit)
        begin
            hit_idx_reg  <= rd_idx_reg;
            own_ok_reg   <= (rd_owner_reg == owner_reg);
            hit_busy_reg <= busy_reg[rd_idx_reg];
        end
        if (cmd.load_rsp)
        begin
            out_status_reg <= cmd.status;
            out_id_reg     <= give_id ? next_ident_reg : '0;
        end
    end

    // slot memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.commit && is_alloc)
        begin
            mem_ident[hit_idx_reg] <= next_ident_reg;
            mem_owner[hit_idx_reg] <= owner_reg;
        end
        if (issue)
        begin
            rd_ident_reg <= mem_ident[scan_cnt_reg[IW-1:0]];
            rd_owner_reg <= mem_owner[scan_cnt_reg[IW-1:0]];
            rd_idx_reg   <= scan_cnt_reg[IW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_priv_reg  <= mot_pkg::FLAG_PRIVATE_RST;
            flag_share_reg <= mot_pkg::FLAG_SHAREABLE_RST;
            flag_guest_reg <= mot_pkg::FLAG_GUEST_RST;
            next_ident_reg <= 64'd1;
            valid_reg      <= '0;
            busy_reg       <= '0;
            scan_cnt_reg   <= '0;
            rd_pend_reg    <= 1'b0;
            out_vld_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    mot_pkg::CFG_FLAG_PRIVATE:   flag_priv_reg  <= cfg_data;
                    mot_pkg::CFG_FLAG_SHAREABLE: flag_share_reg <= cfg_data;
                    mot_pkg::CFG_FLAG_GUEST:     flag_guest_reg <= cfg_data;
                    default:                     ;
                endcase
            end

            if (cmd.scan_start)
            begin
                scan_cnt_reg <= '0;
                rd_pend_reg  <= 1'b0;
            end
            else
            begin
                rd_pend_reg <= issue;
                if (issue)
                begin
                    scan_cnt_reg <= scan_cnt_reg + CW'(1);
                end
            end

            if (cmd.commit)
            begin
                case (cmd_reg)
                    mot_pkg::CMD_ALLOC:
                    begin
                        valid_reg[hit_idx_reg] <= 1'b1;
                        busy_reg[hit_idx_reg]  <= 1'b0;
                        next_ident_reg         <= next_ident_reg + 64'd1;
                    end
                    mot_pkg::CMD_RELEASE:
                    begin
                        valid_reg[hit_idx_reg] <= 1'b0;
                        busy_reg[hit_idx_reg]  <= 1'b0;
                    end
                    mot_pkg::CMD_SET_BUSY:
                    begin
                        busy_reg[hit_idx_reg] <= mark_reg;
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (cmd.load_rsp)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

endmodule

FILE: hw/rtl/memory_object_table_unit.sv
// ---------------------------------------------------------------------------
// Memory object table unit
// Handle table for memory objects: allocate, release and set-busy requests.
// ---------------------------------------------------------------------------
// One request at a time, one response per request. A request is taken while
// idle, checked in the next cycle, then the table is scanned from slot 0
// upward through a single registered read port, one slot per cycle; allocate
// stops at the lowest free slot, release and set-busy stop at the slot
// holding the identifier. A request that fails its field checks skips the
// scan. The response sits in an output register, so a new request is taken
// while the previous response is still waiting. Slot valid bits live in
// flip-flops and clear at reset, so no clearing pass is needed after reset.
// Config writes (three accepted flag codes) take effect at once and must be
// made only while the unit is idle.
// ---------------------------------------------------------------------------
`include "memory_object_table_unit_macros.svh"

module memory_object_table_unit #(
    parameter int SLOTS      = 16,
    parameter int PAGE_SHIFT = 12
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    mot_req_if.sink                          req,
    mot_rsp_if.source                        rsp,
    input  logic                             cfg_we,
    input  logic [mot_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mot_pkg::CFG_DATA_W-1:0]   cfg_data
);

    mot_pkg::ctl_cmd_t cmd;
    mot_pkg::dp_stat_t stat;

    // sequencing: idle -> check -> scan -> decide -> finish
    mot_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    // registers, slot table, scan pipeline, response buffer
    mot_datapath #(
        .SLOTS      (SLOTS),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat)
    );

    // a failed request never hands out an identifier
    `MOT_ASSERT_IMPLY(a_fail_no_id, clk, rst_n, rsp.valid && (rsp.status != mot_pkg::ST_OK), rsp.new_object_id == '0)

    // a taken request blocks the next one
    `MOT_ASSERT_NEXT(a_busy_after_take, clk, rst_n, req.valid && req.ready, !req.ready)

    // the table is only updated when the response is loaded
    `MOT_ASSERT_IMPLY(a_commit_with_rsp, clk, rst_n, cmd.commit, cmd.load_rsp && (cmd.status == mot_pkg::ST_OK))

    // no request is taken during a scan
    `MOT_ASSERT_IMPLY(a_no_take_in_scan, clk, rst_n, cmd.scan, !req.ready)

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Memory object table unit testbench
// Drives allocate, release and set-busy requests and configuration writes of
// the three accepted flag codes. A handle table predictor, kept in a small
// scoreboard class, works out the status and identifier of every request.
// Each response is checked in order against those expectations.
// ---------------------------------------------------------------------------
module tb_top;

    localparam int SLOTS      = 16;
    localparam int PAGE_SHIFT = 12;

    // the one command code with no meaning: the block must answer invalid
    localparam logic [mot_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    // flag code registers in write order
    localparam logic [mot_pkg::CFG_IDX_W-1:0] FLAG_REGS [3] =
        '{mot_pkg::CFG_FLAG_PRIVATE, mot_pkg::CFG_FLAG_SHAREABLE, mot_pkg::CFG_FLAG_GUEST};

    localparam int ITEMS_PER_PHASE = 246;
    localparam int LONG_HOLD       = 300;

    typedef struct {
        logic [mot_pkg::CMD_W-1:0]  command;
        logic [mot_pkg::ID_W-1:0]   owner_id;
        logic [mot_pkg::ID_W-1:0]   object_id;
        logic [mot_pkg::ID_W-1:0]   region_bytes;
        logic [mot_pkg::FLAG_W-1:0] flag_code;
        logic [mot_pkg::RSVD_W-1:0] reserved_word;
        logic                       busy_mark;
    } table_request_t;

    typedef struct {
        mot_pkg::status_t         status;
        logic [mot_pkg::ID_W-1:0] ident;
    } table_response_t;

    // -----------------------------------------------------------------------
    // Scoreboard: a private copy of the handle table plus the responses that
    // are still owed, oldest first.
    // -----------------------------------------------------------------------
    class handle_table_scoreboard;
        logic [mot_pkg::FLAG_W-1:0] private_code;
        logic [mot_pkg::FLAG_W-1:0] shareable_code;
        logic [mot_pkg::FLAG_W-1:0] guest_code;

        bit                         slot_live  [SLOTS];
        logic [mot_pkg::ID_W-1:0]   slot_ident [SLOTS];
        logic [mot_pkg::ID_W-1:0]   slot_owner [SLOTS];
        logic [mot_pkg::ID_W-1:0]   slot_size  [SLOTS];
        logic [mot_pkg::FLAG_W-1:0] slot_flag  [SLOTS];
        bit                         slot_busy  [SLOTS];
        logic [mot_pkg::ID_W-1:0]   next_ident;

        table_response_t   owed_responses[$];
        int                errors;

        function new();
            private_code   = mot_pkg::FLAG_PRIVATE_RST;
            shareable_code = mot_pkg::FLAG_SHAREABLE_RST;
            guest_code     = mot_pkg::FLAG_GUEST_RST;
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_live[i]  = 1'b0;
                slot_ident[i] = '0;
                slot_owner[i] = '0;
                slot_size[i]  = '0;
                slot_flag[i]  = '0;
                slot_busy[i]  = 1'b0;
            end
            next_ident = 64'd1;
            errors     = 0;
        endfunction

        function void set_flag_code(logic [mot_pkg::CFG_IDX_W-1:0] idx,
                                    logic [mot_pkg::FLAG_W-1:0] value);
            case (idx)
                mot_pkg::CFG_FLAG_PRIVATE:   private_code   = value;
                mot_pkg::CFG_FLAG_SHAREABLE: shareable_code = value;
                mot_pkg::CFG_FLAG_GUEST:     guest_code     = value;
                default: ;
            endcase
        endfunction

        function int find_ident(logic [mot_pkg::ID_W-1:0] id);
            for (int i = 0; i < SLOTS; i++)
                if (slot_live[i] && slot_ident[i] == id)
                    return i;
            return -1;
        endfunction

        function int pending();
            return owed_responses.size();
        endfunction

        // Apply one accepted request to the table and queue its response.
        function void note_request(table_request_t r);
            table_response_t rsp;
            int              s;
            rsp.status = mot_pkg::ST_OK;
            rsp.ident  = '0;
            s          = -1;
            case (r.command)
                mot_pkg::CMD_ALLOC:
                begin
                    if (r.owner_id == '0 || r.reserved_word != '0 || r.region_bytes == '0 ||
                        r.region_bytes[PAGE_SHIFT-1:0] != '0 ||
                        (r.flag_code != private_code && r.flag_code != shareable_code &&
                         r.flag_code != guest_code))
                        rsp.status = mot_pkg::ST_INVALID;
                    else
                    begin
                        for (int i = SLOTS - 1; i >= 0; i--)
                            if (!slot_live[i])
                                s = i;
                        // counter pinned at all ones cannot hand out another id
                        if (s < 0 || next_ident == '1)
                            rsp.status = mot_pkg::ST_EXHAUSTED;
                        else
                        begin
                            slot_live[s]  = 1'b1;
                            slot_ident[s] = next_ident;
                            slot_owner[s] = r.owner_id;
                            slot_size[s]  = r.region_bytes;
                            slot_flag[s]  = r.flag_code;
                            slot_busy[s]  = 1'b0;
                            rsp.ident     = next_ident;
                            next_ident    = next_ident + 64'd1;
                        end
                    end
                end
                mot_pkg::CMD_RELEASE:
                begin
                    if (r.object_id == '0 || r.owner_id == '0)
                        rsp.status = mot_pkg::ST_INVALID;
                    else
                    begin
                        s = find_ident(r.object_id);
                        if (s < 0)
                            rsp.status = mot_pkg::ST_NOT_FOUND;
                        else if (slot_owner[s] != r.owner_id)
                            rsp.status = mot_pkg::ST_DENIED;
                        else if (slot_busy[s])
                            rsp.status = mot_pkg::ST_BUSY;
                        else
                        begin
                            slot_live[s]  = 1'b0;
                            slot_ident[s] = '0;
                            slot_owner[s] = '0;
                            slot_size[s]  = '0;
                            slot_flag[s]  = '0;
                            slot_busy[s]  = 1'b0;
                        end
                    end
                end
                mot_pkg::CMD_SET_BUSY:
                begin
                    // no owner check on purpose: stands in for the mapping side
                    if (r.object_id == '0)
                        rsp.status = mot_pkg::ST_INVALID;
                    else
                    begin
                        s = find_ident(r.object_id);
                        if (s < 0)
                            rsp.status = mot_pkg::ST_NOT_FOUND;
                        else
                            slot_busy[s] = r.busy_mark;
                    end
                end
                default: rsp.status = mot_pkg::ST_INVALID;
            endcase
            owed_responses.push_back(rsp);
        endfunction

        function void check_response(logic [mot_pkg::STAT_W-1:0] status,
                                     logic [mot_pkg::ID_W-1:0] ident);
            table_response_t want;
            if (owed_responses.size() == 0)
            begin
                errors++;
                $display("%0t: response with no request pending: status %0d id %h",
                         $time, status, ident);
                return;
            end
            want = owed_responses.pop_front();
            if (status !== want.status)
            begin
                errors++;
                $display("%0t: status mismatch: expected %0d actual %0d",
                         $time, want.status, status);
            end
            if (ident !== want.ident)
            begin
                errors++;
                $display("%0t: new_object_id mismatch: expected %h actual %h",
                         $time, want.ident, ident);
            end
        endfunction
    endclass

    // -----------------------------------------------------------------------
    // DUT and channels
    // -----------------------------------------------------------------------
    logic clk;
    logic rst_n;
    logic                           cfg_we;
    logic [mot_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [mot_pkg::CFG_DATA_W-1:0] cfg_data;

    mot_req_if req_ch ();
    mot_rsp_if rsp_ch ();

    memory_object_table_unit #(
        .SLOTS      (SLOTS),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch.sink),
        .rsp       (rsp_ch.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    handle_table_scoreboard sb;

    // shared run controls: random gaps on both sides, and the long
    // response hold-off that backs the block up into its request side
    bit                       idle_enable;
    bit                       long_hold_request;
    logic [mot_pkg::ID_W-1:0] owner_pool [4];

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // hard stop well past the slowest legal run
    initial
    begin
        #1000000;
        $display("simulation failed");
        $finish;
    end

    // -----------------------------------------------------------------------
    // Request side helpers
    // -----------------------------------------------------------------------
    function automatic table_request_t make_request(
        logic [mot_pkg::CMD_W-1:0] command, logic [mot_pkg::ID_W-1:0] owner_id,
        logic [mot_pkg::ID_W-1:0] object_id, logic [mot_pkg::ID_W-1:0] region_bytes,
        logic [mot_pkg::FLAG_W-1:0] flag_code, logic [mot_pkg::RSVD_W-1:0] reserved_word,
        logic busy_mark);
        table_request_t r;
        r.command       = command;
        r.owner_id      = owner_id;
        r.object_id     = object_id;
        r.region_bytes  = region_bytes;
        r.flag_code     = flag_code;
        r.reserved_word = reserved_word;
        r.busy_mark     = busy_mark;
        return r;
    endfunction

    // Mostly well-formed traffic aimed at live table entries; the rest is
    // noise that hits every field check. alloc_pct sets how hard the table
    // is pushed toward full.
    function automatic table_request_t random_request(int alloc_pct);
        table_request_t r;
        int             live[$];
        int             pick;
        int             k;
        r = make_request(2'($urandom), {$urandom, $urandom}, {$urandom, $urandom},
                         {$urandom, $urandom}, 16'($urandom), $urandom, 1'($urandom));
        for (int i = 0; i < SLOTS; i++)
            if (sb.slot_live[i])
                live.push_back(i);
        pick = $urandom_range(0, 99);
        if (pick < alloc_pct)
        begin
            r.command       = mot_pkg::CMD_ALLOC;
            r.owner_id      = owner_pool[$urandom_range(0, 3)];
            r.reserved_word = '0;
            if ($urandom_range(0, 3) == 0)
                r.region_bytes = {$urandom, $urandom} << PAGE_SHIFT;
            else
                r.region_bytes = 64'($urandom_range(1, 64)) << PAGE_SHIFT;
            if (r.region_bytes == '0)
                r.region_bytes = 64'd1 << PAGE_SHIFT;
            case ($urandom_range(0, 2))
                0:       r.flag_code = sb.private_code;
                1:       r.flag_code = sb.shareable_code;
                default: r.flag_code = sb.guest_code;
            endcase
        end
        else if (pick < alloc_pct + (100 - alloc_pct) / 2)
        begin
            r.command = mot_pkg::CMD_RELEASE;
            if (live.size() > 0)
            begin
                k           = live[$urandom_range(0, live.size() - 1)];
                r.object_id = sb.slot_ident[k];
                // a wrong owner now and then gives denied
                r.owner_id  = ($urandom_range(0, 4) == 0) ? owner_pool[$urandom_range(0, 3)]
                                                          : sb.slot_owner[k];
            end
        end
        else if (pick < alloc_pct + (100 - alloc_pct) * 3 / 4)
        begin
            r.command = mot_pkg::CMD_SET_BUSY;
            if (live.size() > 0)
                r.object_id = sb.slot_ident[live[$urandom_range(0, live.size() - 1)]];
            r.busy_mark = ($urandom_range(0, 2) == 0);
        end
        else
        begin
            // noise: random command with each field check tripped at random
            if ($urandom_range(0, 3) == 0)
                r.owner_id = '0;
            if ($urandom_range(0, 3) == 0)
                r.object_id = '0;
            else if ($urandom_range(0, 2) == 0)
                r.object_id = 64'($urandom_range(1, 32'(sb.next_ident)));
            if ($urandom_range(0, 1) == 0)
                r.reserved_word = '0;
            if ($urandom_range(0, 1) == 0)
                r.region_bytes[PAGE_SHIFT-1:0] = '0;
            if ($urandom_range(0, 1) == 0)
                r.flag_code = sb.guest_code;
        end
        return r;
    endfunction

    // Offer one request and hold it until the block takes it. valid stays
    // high into the next request unless a gap is drawn.
    task automatic send_request(input table_request_t r);
        if (idle_enable && $urandom_range(0, 3) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.command       <= r.command;
        req_ch.owner_id      <= r.owner_id;
        req_ch.object_id     <= r.object_id;
        req_ch.region_bytes  <= r.region_bytes;
        req_ch.flag_code     <= r.flag_code;
        req_ch.reserved_word <= r.reserved_word;
        req_ch.busy_mark     <= r.busy_mark;
        do @(posedge clk); while (!req_ch.ready);
        sb.note_request(r);
    endtask

    // Stop offering and wait for every owed response, then settle.
    task automatic drain_requests(input int settle_cycles);
        req_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (settle_cycles) @(posedge clk);
    endtask

    // Write all three flag code registers, one per cycle; block must be idle.
    task automatic write_flag_codes(input logic [mot_pkg::FLAG_W-1:0] priv,
                                    input logic [mot_pkg::FLAG_W-1:0] shr,
                                    input logic [mot_pkg::FLAG_W-1:0] guest);
        logic [mot_pkg::FLAG_W-1:0] codes [3];
        codes  = '{priv, shr, guest};
        cfg_we <= 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            cfg_index <= FLAG_REGS[i];
            cfg_data  <= codes[i];
            @(posedge clk);
            sb.set_flag_code(FLAG_REGS[i], codes[i]);
        end
        cfg_we <= 1'b0;
    endtask

    // -----------------------------------------------------------------------
    // Response side: check on every handshake, then pick ready for the next
    // edge. Short random stalls, plus one long hold-off counted here.
    // -----------------------------------------------------------------------
    initial
    begin
        int hold_left;
        hold_left    = 0;
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready)
                sb.check_response(rsp_ch.status, rsp_ch.new_object_id);
            if (long_hold_request)
            begin
                hold_left         = LONG_HOLD;
                long_hold_request = 1'b0;
            end
            else if (hold_left == 0 && idle_enable && $urandom_range(0, 7) == 0)
                hold_left = $urandom_range(1, 13);
            if (hold_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold_left--;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // -----------------------------------------------------------------------
    // Main sequence
    // -----------------------------------------------------------------------
    initial
    begin
        int alloc_pct;
        sb                   = new();
        idle_enable          = 1'b1;
        long_hold_request    = 1'b0;
        owner_pool[0]        = 64'd1;
        owner_pool[1]        = '1;
        owner_pool[2]        = {$urandom, $urandom} | 64'd2;
        owner_pool[3]        = {$urandom, $urandom} | 64'h8000_0000_0000_0000;

        rst_n                <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_index            <= '0;
        cfg_data             <= '0;
        req_ch.valid         <= 1'b0;
        req_ch.command       <= '0;
        req_ch.owner_id      <= '0;
        req_ch.object_id     <= '0;
        req_ch.region_bytes  <= '0;
        req_ch.flag_code     <= '0;
        req_ch.reserved_word <= '0;
        req_ch.busy_mark     <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, reset flag codes (1, 2, 4). Allocate field checks:
        // zero owner, nonzero reserved word, zero size, size off a page
        // boundary (also all ones), flag code matching no register.
        send_request(make_request(mot_pkg::CMD_ALLOC, '0, '0, 64'h1000,
                                  mot_pkg::FLAG_PRIVATE_RST, '0, 1'b0));
        send_request(make_request(mot_pkg::CMD_ALLOC, 64'd5, '0, 64'h1000,
                                  mot_pkg::FLAG_PRIVATE_RST, '1, 1'b0));
        send_request(make_request(mot_pkg::CMD_ALLOC, 64'd5, '0, '0,
                                  mot_pkg::FLAG_PRIVATE_RST, '0, 1'b0));
        send_request(make_request(mot_pkg::CMD_ALLOC, 64'd5, '0, 64'h800,
                                  mot_pkg::FLAG_PRIVATE_RST, '0, 1'b0));
        send_request(make_request(mot_pkg::CMD_ALLOC, 64'd5, '0, '1,
                                  mot_pkg::FLAG_PRIVATE_RST, '0, 1'b0));
        send_request(make_request(mot_pkg::CMD_ALLOC, 64'd5, '0, 64'h1000, 16'h0003, '0, 1'b0));
        // good allocates on each flag code, largest aligned size, extreme owner
        send_request(make_request(mot_pkg::CMD_ALLOC, '1, '1, 64'hFFFF_FFFF_FFFF_F000,
                                  mot_pkg::FLAG_PRIVATE_RST, '0, 1'b1));
        send_request(make_request(mot_pkg::CMD_ALLOC, 64'd1, '0, 64'h1000,
                                  mot_pkg::FLAG_SHAREABLE_RST, '0, 1'b0));
        send_request(make_request(mot_pkg::CMD_ALLOC, 64'd7, '0, 64'h1_0000,
                                  mot_pkg::FLAG_GUEST_RST, '0, 1'b0));
        // release: zero id, zero owner, unknown id, wrong owner
        send_request(make_request(mot_pkg::CMD_RELEASE, 64'd1, '0, '0, '0, '0, 1'b0));
        send_request(make_request(mot_pkg::CMD_RELEASE, '0, 64'd2, '0, '0, '0, 1'b0));
        send_request(make_request(mot_pkg::CMD_RELEASE, 64'd1, '1, '0, '0, '0, 1'b0));
        send_request(make_request(mot_pkg::CMD_RELEASE, 64'd1, 64'd1, '0, '0, '0, 1'b0));
        // set busy: zero id, unknown id, then a mark set with no owner given
        send_request(make_request(mot_pkg::CMD_SET_BUSY, 64'd3, '0, '0, '0, '0, 1'b1));
        send_request(make_request(mot_pkg::CMD_SET_BUSY, 64'd3, 64'd99, '0, '0, '0, 1'b1));
        send_request(make_request(mot_pkg::CMD_SET_BUSY, '0, 64'd2, '0, '0, '0, 1'b1));
        // busy entry refuses release until the mark is cleared
        send_request(make_request(mot_pkg::CMD_RELEASE, 64'd1, 64'd2, '0, '0, '0, 1'b0));
        send_request(make_request(mot_pkg::CMD_SET_BUSY, '0, 64'd2, '0, '0, '0, 1'b0));
        send_request(make_request(mot_pkg::CMD_RELEASE, 64'd1, 64'd2, '0, '0, '0, 1'b0));
        // unused command code
        send_request(make_request(CMD_UNUSED, '1, 64'd1, 64'h1000,
                                  mot_pkg::FLAG_PRIVATE_RST, '0, 1'b1));
        // freed slot is reused first, then the all-ones owner releases its entry
        send_request(make_request(mot_pkg::CMD_ALLOC, '1, '0, 64'h1000,
                                  mot_pkg::FLAG_GUEST_RST, '0, 1'b0));
        send_request(make_request(mot_pkg::CMD_RELEASE, '1, 64'd1, '0, '0, '0, 1'b0));

        // Random phases, each under its own flag code setting. Phase 1 leans
        // on allocate to keep the table full, phase 3 keeps it mostly empty.
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                1: write_flag_codes(16'h0000, 16'hFFFF, 16'h8000);
                2: write_flag_codes(16'hFFFF, 16'h0000, 16'($urandom));
                3: write_flag_codes(16'($urandom), 16'($urandom), 16'h0000);
                4: write_flag_codes(mot_pkg::FLAG_PRIVATE_RST, mot_pkg::FLAG_SHAREABLE_RST,
                                    16'hFFFF);
                default: ;
            endcase
            alloc_pct = (phase == 1) ? 55 : (phase == 3) ? 20 : 30;
            // last phase runs at full rate on both sides
            idle_enable = (phase != 4);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (phase != 4 && n % 40 == 39)
                    idle_enable = ($urandom_range(0, 3) != 0);
                // long response hold-off while requests keep coming
                if (phase == 0 && n == 60)
                    long_hold_request = 1'b1;
                // request side waits for the table to go quiet mid-phase
                if (phase == 2 && n == 120)
                    drain_requests(0);
                send_request(random_request(alloc_pct));
            end
            drain_requests(4);
        end

        drain_requests(25);
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/mot_pkg.sv
hw/rtl/mot_req_if.sv
hw/rtl/mot_rsp_if.sv
hw/rtl/mot_ctrl.sv
hw/rtl/mot_datapath.sv
hw/rtl/memory_object_table_unit.sv
verif/tb_top.sv
